/* design/dvrt_pkg.sv */
// Package with shared types and constants for the distance-vector route table.
`timescale 1ns / 1ps
package dvrt_pkg;
  localparam int NUM_NODES_DEF = 256;
  localparam logic [15:0] COST_UNREACH = 16'hFFFF;
  localparam logic [15:0] REFRESH_RESET = 16'd45;

  typedef enum logic [2:0] {
    CMD_DV_ENTRY = 3'd0,
    CMD_LINK     = 3'd1,
    CMD_TICK     = 3'd2,
    CMD_PURGE    = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_ADV_READ = 3'd5
  } cmd_t;

  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
endpackage

/* design/distance_vector_route_table_core.sv */
// Top level of the distance-vector route table: sequencer, entry memory and APB port.
//
//  Channel   Signals                                        Handshake
//  command   start, command, neighbor, dest, adv_cost, ...  start && !busy
//  result    done, changed, found, fwd_hop, out_dest, ...   done strobe, one cycle
//  config    psel, penable, pwrite, paddr, pwdata, prdata   APB, pready tied high
//
// A single-entry command (dv entry without last_entry, lookup, read) is busy through four
// steps: memory read issue, registered read data, update, result register. done is high in the
// cycle after, and the next item can be accepted in that same cycle.
// Scanning commands (vector end, link update, tick, purge) walk every entry through the
// one memory port, with a read, a wait and an update step for each entry.
// Reset clears valid and seen bits at once; no clearing pass is needed.
// The receiver cannot stall: a result is shown for one cycle with done high.
`timescale 1ns / 1ps
module distance_vector_route_table_core #(
  parameter int NUM_NODES = dvrt_pkg::NUM_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [7:0]  neighbor,
  input  logic [7:0]  dest,
  input  logic [15:0] adv_cost,
  input  logic [15:0] link_cost,
  input  logic [15:0] prev_link_cost,
  input  logic        last_entry,
  output logic        done,
  output logic        changed,
  output logic        found,
  output logic [7:0]  fwd_hop,
  output logic [7:0]  out_dest,
  output logic [15:0] out_cost,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dvrt_pkg::*;

  localparam int IW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int CW = IW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_WAIT, S_UPD, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_UPD, S_DONE
  } state_t;

  // Configuration registers.
  logic [7:0]  own_id;
  logic [15:0] age_limit;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= 8'd0;
      age_limit <= REFRESH_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_THRESHOLD[0] && paddr[1:0] == 2'b00) begin
        age_limit <= pwdata[15:0];
      end else if (paddr == 3'd0) begin
        own_id <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == 3'd0) prdata = {24'd0, own_id};
    else if (paddr == 3'd4) prdata = {16'd0, age_limit};
  end

  // Route memory: cost, next hop and age in one word; valid and seen in flops.
  logic [55:0]          mem [NUM_NODES];
  logic [55:0]          rdata;
  logic [IW-1:0]        raddr;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic [55:0]          wdata;
  logic [NUM_NODES-1:0] valid;
  logic [NUM_NODES-1:0] seen;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Latched command.
  state_t      state;
  cmd_t        cmd;
  logic [7:0]  nb, dst;
  logic [15:0] adv, lnk, prv;
  logic        last, vchg, chg;
  logic [CW-1:0] idx;
  logic        dst_ok;

  assign dst_ok = (32'(dst) < 32'(NUM_NODES));

  wire [31:0] r_cost = rdata[55:24];
  wire [7:0]  r_hop  = rdata[23:16];
  wire [15:0] r_age  = rdata[15:0];
  wire [IW-1:0] cur  = idx[IW-1:0];
  wire [IW-1:0] dix  = IW'(dst);
  wire [31:0] sum    = {16'd0, lnk} + {16'd0, adv};

  assign busy = (state != S_IDLE);

  always_comb begin
    raddr = (state == S_SCAN_RD || state == S_SCAN_WAIT || state == S_SCAN_UPD)
            ? cur : dix;
  end

  // Sequencer with the compare/add logic of the update states.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      seen  <= '0;
      vchg  <= 1'b0;
      done  <= 1'b0;
      we    <= 1'b0;
    end else begin
      done <= 1'b0;
      we   <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= cmd_t'(command);
            nb <= neighbor; dst <= dest; adv <= adv_cost; lnk <= link_cost;
            prv <= prev_link_cost; last <= last_entry;
            chg <= 1'b0; found <= 1'b0; fwd_hop <= 8'd0;
            out_dest <= 8'd0; out_cost <= 16'd0; idx <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          // Link update looks at the neighbor's own entry first.
          if (cmd == CMD_LINK) dst <= nb;
          state <= S_WAIT;
        end
        S_WAIT: state <= S_UPD;
        S_UPD: begin
          state <= S_DONE;
          case (cmd) inside
            CMD_DV_ENTRY: begin
              if (dst != own_id && adv != COST_UNREACH && dst_ok) begin
                seen[dix] <= 1'b1;
                if (!valid[dix] || sum < r_cost) begin
                  valid[dix] <= 1'b1;
                  we <= 1'b1; waddr <= dix;
                  wdata <= {sum, nb, 16'd0};
                  chg <= 1'b1; vchg <= 1'b1;
                end else if (r_hop == nb) begin
                  we <= 1'b1; waddr <= dix;
                  wdata <= {r_cost, r_hop, 16'd0};
                  if (r_cost != sum) begin
                    chg <= 1'b1; vchg <= 1'b1;
                  end
                end
              end
              if (last) state <= S_SCAN_RD;
            end
            CMD_LINK: begin
              if (lnk != COST_UNREACH && dst_ok &&
                  (!valid[dix] ||
                   (r_hop != nb && {16'd0, lnk} < r_cost))) begin
                valid[dix] <= 1'b1;
                we <= 1'b1; waddr <= dix;
                wdata <= {16'd0, lnk, nb, 16'd0};
                chg <= 1'b1;
              end
              state <= S_SCAN_RD;
            end
            CMD_TICK, CMD_PURGE: state <= S_SCAN_RD;
            CMD_LOOKUP: begin
              if (dst == own_id) begin
                found <= 1'b1; fwd_hop <= own_id;
              end else if (dst_ok && valid[dix]) begin
                found <= 1'b1; fwd_hop <= r_hop;
              end
            end
            CMD_ADV_READ: begin
              out_dest <= dst;
              if (dst_ok && valid[dix]) begin
                found <= 1'b1;
                out_cost <= (r_hop == nb) ? COST_UNREACH : r_cost[15:0];
              end
            end
            default: ;
          endcase
        end
        S_SCAN_RD: state <= S_SCAN_WAIT;
        S_SCAN_WAIT: state <= S_SCAN_UPD;
        S_SCAN_UPD: begin
          if (valid[cur]) begin
            case (cmd)
              CMD_DV_ENTRY: begin
                if (r_hop == nb && 32'(nb) != 32'(idx) && !seen[cur]) begin
                  vchg <= 1'b1;
                  if (32'(own_id) != 32'(idx)) valid[cur] <= 1'b0;
                end
              end
              CMD_LINK: begin
                if (r_hop == nb) begin
                  if (lnk == COST_UNREACH) begin
                    chg <= 1'b1;
                    if (32'(own_id) != 32'(idx)) valid[cur] <= 1'b0;
                  end else begin
                    we <= 1'b1; waddr <= cur;
                    wdata <= {r_cost + {16'd0, lnk} - {16'd0, prv}, r_hop, 16'd0};
                    if (lnk != prv) chg <= 1'b1;
                  end
                end
              end
              CMD_TICK: begin
                if (r_age != 16'hFFFF) begin
                  we <= 1'b1; waddr <= cur;
                  wdata <= {r_cost, r_hop, r_age + 16'd1};
                end
              end
              CMD_PURGE: begin
                if (r_age > age_limit) begin
                  chg <= 1'b1;
                  if (32'(own_id) != 32'(idx)) valid[cur] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
          if (idx == CW'(NUM_NODES - 1)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (cmd == CMD_DV_ENTRY && last) begin
            chg <= vchg;
            seen <= '0;
            vchg <= 1'b0;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign changed = chg;

  // The result strobe always follows a busy cycle and lasts one cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a command in flight");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_no_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done) else $error("result too early");
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy) else $error("memory write while idle");
endmodule
